// File: hdl/plq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plq_pkg: shared types and constants of the price level order queue
// Holds the field widths, operation codes, controller states and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package plq_pkg;

  // Default number of order slots in the pool.
  localparam int unsigned ORDER_SLOTS_DEF = 1024;

  // Fixed field widths.
  localparam int unsigned SIZE_W  = 32;
  localparam int unsigned VOL_W   = 48;
  localparam int unsigned PRICE_W = 32;

  // Operation codes carried on the operation field.
  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // Controller states.
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;   // write one membership entry of the clearing sweep
    logic accept;  // capture the request and read the slot memories
    logic exec;    // update links, pointers, count and volume
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;  // the sweep is at its last entry
  } sts_t;

endpackage

// File: hdl/plq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plq_ctrl: controller of the price level order queue
// Runs the membership clearing sweep after reset, then sequences each
// request through its read cycle and its update cycle.
// ----------------------------------------------------------------------------
module plq_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  plq_pkg::sts_t sts_i,
  output plq_pkg::cmd_t cmd_o,
  output logic          busy
);

  plq_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= plq_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      plq_pkg::ST_CLEAR: begin
        if (sts_i.clr_last) begin
          state_d = plq_pkg::ST_IDLE;
        end
      end
      plq_pkg::ST_IDLE: begin
        if (start) begin
          state_d = plq_pkg::ST_EXEC;
        end
      end
      plq_pkg::ST_EXEC: begin
        state_d = plq_pkg::ST_IDLE;
      end
      default: begin
        state_d = plq_pkg::ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    cmd_o = '0;
    busy  = 1'b1;
    case (state_q)
      plq_pkg::ST_CLEAR: begin
        cmd_o.clear = 1'b1;
      end
      plq_pkg::ST_IDLE: begin
        busy         = 1'b0;
        cmd_o.accept = start;
      end
      plq_pkg::ST_EXEC: begin
        cmd_o.exec = 1'b1;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

// File: hdl/plq_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plq_datapath: link memories, pointers and totals of the order queue
// Holds the membership and link memories, head and tail pointers, the
// order count, the saturating volume and the price register.
// ----------------------------------------------------------------------------
module plq_datapath #(
  parameter int unsigned ORDER_SLOTS = plq_pkg::ORDER_SLOTS_DEF,
  localparam int unsigned SLOT_W = $clog2(ORDER_SLOTS),
  localparam int unsigned PTR_W  = $clog2(ORDER_SLOTS + 1)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  plq_pkg::cmd_t                     cmd_i,
  output plq_pkg::sts_t                     sts_o,
  input  logic                              level_price_we_i,
  input  logic signed [plq_pkg::PRICE_W-1:0] level_price_i,
  input  logic                              operation_i,
  input  logic [SLOT_W-1:0]                 order_slot_i,
  input  logic [plq_pkg::SIZE_W-1:0]        order_size_i,
  output logic                              done_o,
  output logic [plq_pkg::VOL_W-1:0]         total_volume_o,
  output logic [PTR_W-1:0]                  order_count_o,
  output logic [PTR_W-1:0]                  head_slot_o,
  output logic [PTR_W-1:0]                  tail_slot_o,
  output logic                              level_empty_o,
  output logic                              op_error_o
);

  localparam logic [PTR_W-1:0]  NONE      = PTR_W'(ORDER_SLOTS);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(ORDER_SLOTS - 1);

  // Memories.
  logic             q_mem [ORDER_SLOTS];
  logic [PTR_W-1:0] n_mem [ORDER_SLOTS];
  logic [PTR_W-1:0] p_mem [ORDER_SLOTS];

  // Captured request and registered read data.
  logic                       op_q;
  logic [SLOT_W-1:0]          slot_q;
  logic [plq_pkg::SIZE_W-1:0] size_q;
  logic                       inrange_q;
  logic                       q_rd_q;
  logic [PTR_W-1:0]           n_rd_q;
  logic [PTR_W-1:0]           p_rd_q;

  // Level state.
  logic [PTR_W-1:0]                   head_q, head_d;
  logic [PTR_W-1:0]                   tail_q, tail_d;
  logic [PTR_W-1:0]                   count_q, count_d;
  logic [plq_pkg::VOL_W-1:0]          vol_q, vol_d;
  logic [SLOT_W-1:0]                  clr_addr_q;
  logic                               done_q;
  logic                               err_q;
  logic signed [plq_pkg::PRICE_W-1:0] level_price_q;

  // Update logic.
  logic                      do_add, do_rem;
  logic [PTR_W-1:0]          slot_ptr, prev_eff, next_eff;
  logic                      tail_valid, prev_valid, next_valid;
  logic [plq_pkg::VOL_W:0]   add_sum;
  logic [plq_pkg::VOL_W-1:0] size_ext;

  logic              q_we, q_wdata;
  logic [SLOT_W-1:0] q_waddr;
  logic              n_we, p_we;
  logic [SLOT_W-1:0] n_waddr, p_waddr;
  logic [PTR_W-1:0]  n_wdata, p_wdata;

  assign sts_o.clr_last = (clr_addr_q == LAST_SLOT);

  // Request capture and memory reads.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q      <= operation_i;
      slot_q    <= order_slot_i;
      size_q    <= order_size_i;
      inrange_q <= (PTR_W'(order_slot_i) < NONE);
      q_rd_q    <= q_mem[order_slot_i];
      n_rd_q    <= n_mem[order_slot_i];
      p_rd_q    <= p_mem[order_slot_i];
    end
  end

  assign slot_ptr   = PTR_W'(slot_q);
  assign do_add     = cmd_i.exec && inrange_q && (op_q == plq_pkg::OP_APPEND) && !q_rd_q;
  assign do_rem     = cmd_i.exec && inrange_q && (op_q == plq_pkg::OP_REMOVE) && q_rd_q;
  // The head's prev link and the tail's next link are not taken from the memories.
  assign prev_eff   = (slot_ptr == head_q) ? NONE : p_rd_q;
  assign next_eff   = (slot_ptr == tail_q) ? NONE : n_rd_q;
  assign tail_valid = (tail_q != NONE);
  assign prev_valid = (prev_eff != NONE);
  assign next_valid = (next_eff != NONE);
  assign size_ext   = plq_pkg::VOL_W'(size_q);
  assign add_sum    = {1'b0, vol_q} + {1'b0, size_ext};

  // Memory write ports.
  always_comb begin
    q_we    = 1'b0;
    q_waddr = slot_q;
    q_wdata = 1'b0;
    if (cmd_i.clear) begin
      q_we    = 1'b1;
      q_waddr = clr_addr_q;
    end else if (do_add) begin
      q_we    = 1'b1;
      q_wdata = 1'b1;
    end else if (do_rem) begin
      q_we    = 1'b1;
    end
  end

  always_comb begin
    n_we    = 1'b0;
    n_waddr = tail_q[SLOT_W-1:0];
    n_wdata = slot_ptr;
    p_we    = 1'b0;
    p_waddr = slot_q;
    p_wdata = tail_q;
    if (do_add) begin
      n_we = tail_valid;
      p_we = 1'b1;
    end else if (do_rem) begin
      n_we    = prev_valid;
      n_waddr = prev_eff[SLOT_W-1:0];
      n_wdata = next_eff;
      p_we    = next_valid;
      p_waddr = next_eff[SLOT_W-1:0];
      p_wdata = prev_eff;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_we) begin
      q_mem[q_waddr] <= q_wdata;
    end
    if (n_we) begin
      n_mem[n_waddr] <= n_wdata;
    end
    if (p_we) begin
      p_mem[p_waddr] <= p_wdata;
    end
  end

  // Pointer, count and volume updates.
  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    vol_d   = vol_q;
    if (do_add) begin
      if (!tail_valid) begin
        head_d = slot_ptr;
      end
      tail_d  = slot_ptr;
      count_d = count_q + PTR_W'(1);
      vol_d   = add_sum[plq_pkg::VOL_W] ? '1 : add_sum[plq_pkg::VOL_W-1:0];
    end else if (do_rem) begin
      if (!prev_valid) begin
        head_d = next_eff;
      end
      if (!next_valid) begin
        tail_d = prev_eff;
      end
      if (count_q != '0) begin
        count_d = count_q - PTR_W'(1);
      end
      vol_d = (size_ext > vol_q) ? '0 : (vol_q - size_ext);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q        <= NONE;
      tail_q        <= NONE;
      count_q       <= '0;
      vol_q         <= '0;
      clr_addr_q    <= '0;
      done_q        <= 1'b0;
      level_price_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      vol_q   <= vol_d;
      done_q  <= cmd_i.exec;
      if (cmd_i.clear) begin
        clr_addr_q <= clr_addr_q + SLOT_W'(1);
      end
      if (level_price_we_i) begin
        level_price_q <= level_price_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      err_q <= !(do_add || do_rem);
    end
  end

  assign done_o         = done_q;
  assign total_volume_o = vol_q;
  assign order_count_o  = count_q;
  assign head_slot_o    = head_q;
  assign tail_slot_o    = tail_q;
  assign level_empty_o  = (count_q == '0);
  assign op_error_o     = err_q;

endmodule

// File: hdl/price_level_order_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// price_level_order_queue: one price level of an order book
// Keeps the orders of one price in arrival order as a doubly linked list
// over a pool of order slots and reports volume, count, head and tail.
// ----------------------------------------------------------------------------
// A request is taken at a rising edge where start is high and busy is low.
// Every request gives exactly one result beat: done_o is high for a single
// cycle, registered from the update state that follows the request, and
// the result ports are valid in that cycle only; the receiver has no way
// to stall it, so it must sample the beat when done_o is high. Busy stays
// high in the update state and drops again in the cycle that carries the
// result, so a new request may be taken in that cycle. The read and update
// steps come from the slot memories: the read step takes the membership
// bit and both links of the slot through registered read ports, the update
// writes the links of the neighbors and updates head, tail, count and
// volume. After reset the block runs a clearing sweep over the membership
// memory, one slot per cycle, and busy stays high until every slot is
// cleared; the price register can be written at any time. The head and
// tail ports read ORDER_SLOTS when the level is empty. Appending a slot that
// is already queued, removing a slot that is not queued, or naming a slot at
// or above ORDER_SLOTS sets op_error_o and leaves the level unchanged. The
// volume saturates at its maximum on append and stops at zero on remove.
// The level price is stored only and never affects a result.
// ----------------------------------------------------------------------------
module price_level_order_queue #(
  parameter int unsigned ORDER_SLOTS = plq_pkg::ORDER_SLOTS_DEF,
  localparam int unsigned SLOT_W = $clog2(ORDER_SLOTS),
  localparam int unsigned PTR_W  = $clog2(ORDER_SLOTS + 1)
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Configuration.
  input  logic                               level_price_we_i,
  input  logic signed [plq_pkg::PRICE_W-1:0] level_price_i,
  // Request.
  input  logic                               start,
  output logic                               busy,
  input  logic                               operation_i,
  input  logic [SLOT_W-1:0]                  order_slot_i,
  input  logic [plq_pkg::SIZE_W-1:0]         order_size_i,
  // Result.
  output logic                               done_o,
  output logic [plq_pkg::VOL_W-1:0]          total_volume_o,
  output logic [PTR_W-1:0]                   order_count_o,
  output logic [PTR_W-1:0]                   head_slot_o,
  output logic [PTR_W-1:0]                   tail_slot_o,
  output logic                               level_empty_o,
  output logic                               op_error_o
);

  // The controller only sequences; all storage sits in the datapath.
  plq_pkg::cmd_t cmd;
  plq_pkg::sts_t sts;

  plq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  plq_datapath #(
    .ORDER_SLOTS (ORDER_SLOTS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .level_price_we_i (level_price_we_i),
    .level_price_i    (level_price_i),
    .operation_i      (operation_i),
    .order_slot_i     (order_slot_i),
    .order_size_i     (order_size_i),
    .done_o           (done_o),
    .total_volume_o   (total_volume_o),
    .order_count_o    (order_count_o),
    .head_slot_o      (head_slot_o),
    .tail_slot_o      (tail_slot_o),
    .level_empty_o    (level_empty_o),
    .op_error_o       (op_error_o)
  );

endmodule

// File: hdl/plq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plq_checker: port level checks of the price level order queue
// Watches requests and result beats on the top level ports.
// ----------------------------------------------------------------------------
module plq_checker #(
  parameter int unsigned ORDER_SLOTS = plq_pkg::ORDER_SLOTS_DEF,
  localparam int unsigned SLOT_W = $clog2(ORDER_SLOTS),
  localparam int unsigned PTR_W  = $clog2(ORDER_SLOTS + 1)
) (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       start,
  input logic                       busy,
  input logic [SLOT_W-1:0]          order_slot_i,
  input logic                       done_o,
  input logic [plq_pkg::VOL_W-1:0]  total_volume_o,
  input logic [PTR_W-1:0]           order_count_o,
  input logic [PTR_W-1:0]           head_slot_o,
  input logic [PTR_W-1:0]           tail_slot_o,
  input logic                       level_empty_o,
  input logic                       op_error_o
);

  localparam logic [PTR_W-1:0] NONE = PTR_W'(ORDER_SLOTS);

  // A taken request is followed by its result beat.
  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> ##1 done_o)
    else $error("result beat missing after a request");

  // A result beat only follows a taken request.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, 2))
    else $error("result beat without a request");

  // Empty flag, count and both pointers agree.
  a_empty_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ((level_empty_o == (order_count_o == '0)) &&
                (level_empty_o == (head_slot_o == NONE)) &&
                (level_empty_o == (tail_slot_o == NONE))))
    else $error("empty flag disagrees with count or pointers");

  // A rejected request leaves the level unchanged.
  a_error_no_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && op_error_o) |-> ((order_count_o == $past(order_count_o, 2)) &&
                                (total_volume_o == $past(total_volume_o, 2)) &&
                                (head_slot_o == $past(head_slot_o, 2)) &&
                                (tail_slot_o == $past(tail_slot_o, 2))))
    else $error("rejected request changed the level");

  // A slot outside the pool is always rejected.
  a_range_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (PTR_W'(order_slot_i) >= NONE)) |=> ##1 op_error_o)
    else $error("out of range slot not rejected");

endmodule

bind price_level_order_queue plq_checker #(
  .ORDER_SLOTS (ORDER_SLOTS)
) u_plq_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .order_slot_i   (order_slot_i),
  .done_o         (done_o),
  .total_volume_o (total_volume_o),
  .order_count_o  (order_count_o),
  .head_slot_o    (head_slot_o),
  .tail_slot_o    (tail_slot_o),
  .level_empty_o  (level_empty_o),
  .op_error_o     (op_error_o)
);
